// ----- src/sstp_pkg.sv -----
package sstp_pkg;

    // Field widths.
    localparam int VALUE_BITS    = 32;
    localparam int POSITION_BITS = 16;
    localparam int KIND_BITS     = 3;
    localparam int STATUS_BITS   = 2;
    localparam int PHASE_BITS    = 4;

    // Stream widths: the result data carries three values, three flags and the position.
    localparam int RESULT_BITS = 3 * VALUE_BITS + 3 + POSITION_BITS;
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
    localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [POSITION_BITS-1:0]     pos_t;
    typedef logic [KIND_BITS-1:0]         kind_t;
    typedef logic [STATUS_BITS-1:0]       status_t;
    typedef logic [PHASE_BITS-1:0]        phase_t;

    // Token kinds.
    localparam kind_t K_LB    = 3'd0;
    localparam kind_t K_RB    = 3'd1;
    localparam kind_t K_COLON = 3'd2;
    localparam kind_t K_INT   = 3'd3;
    localparam kind_t K_END   = 3'd5;

    // Parser phases.
    localparam phase_t PH_WANT_LB    = 4'd0;
    localparam phase_t PH_OPEN       = 4'd1;
    localparam phase_t PH_HAVE_START = 4'd2;
    localparam phase_t PH_COLON1     = 4'd3;
    localparam phase_t PH_HAVE_STOP  = 4'd4;
    localparam phase_t PH_COLON2     = 4'd5;
    localparam phase_t PH_HAVE_STEP  = 4'd6;
    localparam phase_t PH_CLOSED     = 4'd7;
    localparam phase_t PH_SKIP       = 4'd8;

    // Result status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_SYNTAX    = 2'd1;
    localparam status_t ST_ZERO_STEP = 2'd2;

    // Given flags: bit 0 start, bit 1 stop, bit 2 step.
    typedef struct packed {
        phase_t     phase;
        value_t     start_val;
        value_t     stop_val;
        value_t     step_val;
        logic [2:0] given;
        pos_t       index;
    } parse_state_t;

    typedef struct packed {
        status_t    status;
        value_t     start_val;
        value_t     stop_val;
        value_t     step_val;
        logic [2:0] given;
        pos_t       error_position;
    } result_t;

    function automatic parse_state_t state_clear();
        parse_state_t s;
        s.phase     = PH_WANT_LB;
        s.start_val = '0;
        s.stop_val  = '0;
        s.step_val  = '0;
        s.given     = '0;
        s.index     = '0;
        return s;
    endfunction

endpackage

// ----- src/sstp_step.sv -----
module sstp_step
    import sstp_pkg::*;
(
    input  parse_state_t cur,
    input  kind_t        token_kind,
    input  value_t       token_value,
    output parse_state_t nxt,
    output logic         emit,
    output result_t      result
);

    logic    fail;
    status_t fail_status;

    always_comb
    begin
        nxt         = cur;
        fail        = 1'b0;
        fail_status = ST_SYNTAX;
        emit        = 1'b0;

        // The result carries what was recorded before this token.
        result.status         = ST_OK;
        result.start_val      = cur.start_val;
        result.stop_val       = cur.stop_val;
        result.step_val       = cur.step_val;
        result.given          = cur.given;
        result.error_position = '0;

        // Token position saturates at all ones.
        if (cur.index != '1)
        begin
            nxt.index = cur.index + 1'b1;
        end

        case (cur.phase)
            PH_WANT_LB:
            begin
                if (token_kind == K_LB) nxt.phase = PH_OPEN;
                else fail = 1'b1;
            end
            PH_OPEN:
            begin
                if (token_kind == K_RB)
                begin
                    nxt.phase = PH_CLOSED;
                end
                else if (token_kind == K_INT)
                begin
                    nxt.start_val = token_value;
                    nxt.given[0]  = 1'b1;
                    nxt.phase     = PH_HAVE_START;
                end
                else if (token_kind == K_COLON)
                begin
                    nxt.phase = PH_COLON1;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_HAVE_START:
            begin
                if (token_kind == K_COLON) nxt.phase = PH_COLON1;
                else if (token_kind == K_RB) nxt.phase = PH_CLOSED;
                else fail = 1'b1;
            end
            PH_COLON1:
            begin
                if (token_kind == K_INT)
                begin
                    nxt.stop_val = token_value;
                    nxt.given[1] = 1'b1;
                    nxt.phase    = PH_HAVE_STOP;
                end
                else if (token_kind == K_COLON)
                begin
                    nxt.phase = PH_COLON2;
                end
                else if (token_kind == K_RB)
                begin
                    nxt.phase = PH_CLOSED;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_HAVE_STOP:
            begin
                if (token_kind == K_COLON) nxt.phase = PH_COLON2;
                else if (token_kind == K_RB) nxt.phase = PH_CLOSED;
                else fail = 1'b1;
            end
            PH_COLON2:
            begin
                if (token_kind == K_INT)
                begin
                    // A zero step is reported as its own error kind.
                    if (token_value == '0)
                    begin
                        fail        = 1'b1;
                        fail_status = ST_ZERO_STEP;
                    end
                    else
                    begin
                        nxt.step_val = token_value;
                        nxt.given[2] = 1'b1;
                        nxt.phase    = PH_HAVE_STEP;
                    end
                end
                else if (token_kind == K_RB)
                begin
                    nxt.phase = PH_CLOSED;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            PH_HAVE_STEP:
            begin
                if (token_kind == K_RB) nxt.phase = PH_CLOSED;
                else fail = 1'b1;
            end
            PH_CLOSED:
            begin
                if (token_kind == K_END)
                begin
                    emit = 1'b1;
                    nxt  = state_clear();
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            default:
            begin
                // Skipping after an error: only the end marker matters.
                if (token_kind == K_END) nxt = state_clear();
            end
        endcase

        // A failing token reports its own position and starts the skip; a failing end marker clears the state instead.
        if (fail)
        begin
            emit                  = 1'b1;
            result.status         = fail_status;
            result.error_position = cur.index;
            if (token_kind == K_END)
            begin
                nxt = state_clear();
            end
            else
            begin
                nxt           = cur;
                nxt.index     = cur.index != '1 ? cur.index + 1'b1 : cur.index;
                nxt.phase     = PH_SKIP;
            end
        end
    end

endmodule

// ----- src/slice_spec_token_parser.sv -----
// Channel   Direction  tdata                     tuser
// s_*       in         token_value               token_kind
// m_*       out        values, flags, position   status
//
// One token is taken per cycle unless stalled; a result appears on m_* in the
// cycle after its token. The parse state and a single result register set the
// rate. Reset returns the parser to expecting a left bracket with nothing held.
// s_tready stays high while the result register is empty or being drained.
module slice_spec_token_parser
    import sstp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [31:0] token_value
    input  logic [S_DATA_BITS-1:0] s_tdata,
    // [2:0] token_kind
    input  logic [KIND_BITS-1:0]   s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] start_value, [63:32] stop_value, [95:64] step_value,
    // [96] start_given, [97] stop_given, [98] step_given,
    // [114:99] error_position, rest zero
    output logic [M_DATA_BITS-1:0] m_tdata,
    // [1:0] status
    output logic [STATUS_BITS-1:0] m_tuser
);

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      step_result;
    logic         step_emit;
    logic         out_valid_reg;
    logic         in_fire;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // Next parse state and result for the offered token.
    sstp_step u_step (
        .cur         (state_reg),
        .token_kind  (s_tuser),
        .token_value (value_t'(s_tdata[VALUE_BITS-1:0])),
        .nxt         (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    // Parse state advances on each accepted token.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= state_clear();
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && step_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    // Pack the result onto the stream.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.status;
    assign m_tdata  = M_DATA_BITS'({result_reg.error_position,
                                    result_reg.given,
                                    result_reg.step_val,
                                    result_reg.stop_val,
                                    result_reg.start_val});

endmodule
